// ===== rtl/idalloc_pkg.sv =====
// Shared types and constants for the identifier allocator with FIFO recycling.
package idalloc_pkg;

  localparam int unsigned IdBitsDef    = 8;
  localparam int unsigned RingDepthDef = 256;
  localparam int unsigned PortIdW      = 8;
  localparam int unsigned StatusW      = 3;

  typedef enum logic [StatusW-1:0] {
    ST_RECYCLED  = 3'd0,
    ST_FRESH     = 3'd1,
    ST_ACCEPTED  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_DROPPED   = 3'd4
  } status_e;

  typedef struct packed {
    logic    pop;
    logic    push;
    logic    fresh;
    logic    load_now;
    logic    load_fetch;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic fresh_avail;
  } dp_stat_t;

endpackage

// ===== rtl/idalloc_ctrl.sv =====
// Controller state machine that sequences one request or return beat at a time.
module idalloc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  idalloc_pkg::dp_stat_t stat_i,
  output idalloc_pkg::dp_cmd_t  cmd_o
);
  import idalloc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_OUT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    cmd_o.status = ST_RECYCLED;
    state_d     = state_q;
    out_valid_d = out_valid_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            if (!stat_i.empty) begin
              cmd_o.pop = 1'b1;
              state_d   = S_FETCH;
            end else if (stat_i.fresh_avail) begin
              cmd_o.fresh    = 1'b1;
              cmd_o.load_now = 1'b1;
              cmd_o.status   = ST_FRESH;
              state_d        = S_OUT;
              out_valid_d    = 1'b1;
            end else begin
              cmd_o.load_now = 1'b1;
              cmd_o.status   = ST_EXHAUSTED;
              state_d        = S_OUT;
              out_valid_d    = 1'b1;
            end
          end else begin
            cmd_o.load_now = 1'b1;
            if (!stat_i.full) begin
              cmd_o.push   = 1'b1;
              cmd_o.status = ST_ACCEPTED;
            end else begin
              cmd_o.status = ST_DROPPED;
            end
            state_d     = S_OUT;
            out_valid_d = 1'b1;
          end
        end
      end
      S_FETCH: begin
        cmd_o.load_fetch = 1'b1;
        cmd_o.status     = ST_RECYCLED;
        state_d          = S_OUT;
        out_valid_d      = 1'b1;
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == S_OUT))
    else $error("Output valid outside the output state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FETCH) |=> (state_q == S_OUT) && out_valid_q)
    else $error("Ring fetch did not lead to an output beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q && $stable(state_q))
    else $error("Stalled result was lost.");

endmodule

// ===== rtl/idalloc_dp.sv =====
// Datapath with the free-identifier ring memory, pointers, counters and result registers.
module idalloc_dp #(
  parameter int unsigned ID_BITS    = idalloc_pkg::IdBitsDef,
  parameter int unsigned RING_DEPTH = idalloc_pkg::RingDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [idalloc_pkg::PortIdW-1:0]    returned_id_i,
  input  idalloc_pkg::dp_cmd_t               cmd_i,
  output idalloc_pkg::dp_stat_t              stat_o,
  output logic [idalloc_pkg::PortIdW-1:0]    granted_id_o,
  output logic [idalloc_pkg::StatusW-1:0]    status_o
);
  import idalloc_pkg::*;

  localparam int unsigned PtrW  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(RING_DEPTH + 1);
  localparam int unsigned WideW = (ID_BITS > PortIdW) ? ID_BITS : PortIdW;
  localparam logic [PtrW-1:0] PtrLast  = PtrW'(RING_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull  = CntW'(RING_DEPTH);

  logic [ID_BITS-1:0] ring_mem [RING_DEPTH];
  logic [ID_BITS-1:0] rd_q;
  logic [PtrW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [ID_BITS:0]   fresh_q, fresh_d;
  logic [WideW-1:0]   out_id_q;
  status_e            out_status_q;
  logic [WideW-1:0]   ret_wide;

  assign ret_wide = WideW'(returned_id_i);

  assign stat_o.empty       = (count_q == '0);
  assign stat_o.full        = (count_q == CntFull);
  assign stat_o.fresh_avail = !fresh_q[ID_BITS];

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    fresh_d = fresh_q;
    if (cmd_i.pop) begin
      head_d  = (head_q == PtrLast) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end
    if (cmd_i.push) begin
      tail_d  = (tail_q == PtrLast) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
    if (cmd_i.fresh) begin
      fresh_d = fresh_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      fresh_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ring_mem[tail_q] <= ret_wide[ID_BITS-1:0];
    end
    if (cmd_i.pop) begin
      rd_q <= ring_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_fetch) begin
      out_id_q     <= WideW'(rd_q);
      out_status_q <= cmd_i.status;
    end else if (cmd_i.load_now) begin
      out_id_q     <= cmd_i.fresh ? WideW'(fresh_q[ID_BITS-1:0]) : '0;
      out_status_q <= cmd_i.status;
    end
  end

  assign granted_id_o = out_id_q[PortIdW-1:0];
  assign status_o     = out_status_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> !stat_o.empty && !cmd_i.push)
    else $error("Pop issued on an empty ring or together with a push.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !stat_o.full)
    else $error("Push issued on a full ring.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("Ring count exceeds the ring depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.fresh |-> stat_o.fresh_avail && stat_o.empty)
    else $error("Fresh identifier issued while exhausted or with a nonempty ring.");

endmodule

// ===== rtl/id_allocator_free_fifo_top.sv =====
// Top level of the identifier allocator that recycles freed identifiers in FIFO order.
//
//   Channel | Handshake                  | Beat contents
//   --------+----------------------------+------------------------------
//   in      | in_valid_i / in_ready_o    | mode_i, returned_id_i
//   out     | out_valid_o / out_ready_i  | granted_id_o, status_o
//
// One beat is handled at a time: a fresh grant, an exhausted request or a
// return goes from the idle state straight to the output state, and a recycled
// grant passes through a fetch state first because the ring memory read is registered.
// Output stalls hold the result and keep in_ready_o low until it is taken.
// Reset clears the pointers, counters and control state; the ring memory is
// not cleared, as only entries that were written are ever read.
module id_allocator_free_fifo_top #(
  parameter int unsigned ID_BITS    = idalloc_pkg::IdBitsDef,
  parameter int unsigned RING_DEPTH = idalloc_pkg::RingDepthDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            mode_i,
  input  logic [idalloc_pkg::PortIdW-1:0] returned_id_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [idalloc_pkg::PortIdW-1:0] granted_id_o,
  output logic [idalloc_pkg::StatusW-1:0] status_o
);
  import idalloc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  idalloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  idalloc_dp #(
    .ID_BITS   (ID_BITS),
    .RING_DEPTH(RING_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .returned_id_i(returned_id_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .granted_id_o (granted_id_o),
    .status_o     (status_o)
  );

endmodule
